// ===== rtl/modexp_pkg.sv =====
// Package for the modular exponentiation block: sequencer states, widths and
// the control struct passed from the sequencer to the datapath. No dependencies.
package modexp_pkg;

    localparam int BaseW = 32;
    localparam int OpW   = 31;
    localparam int ProdW = 62;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_BASE,
        ST_MUL,
        ST_SQR,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

    // operand select and divider start, from sequencer to datapath
    typedef struct packed {
        logic       start;
        logic [1:0] sel;   // operand pair for the reduction
    } div_ctrl_t;

    localparam logic [1:0] SEL_BASE = 2'd0;
    localparam logic [1:0] SEL_MUL  = 2'd1;
    localparam logic [1:0] SEL_SQR  = 2'd2;

endpackage

// ===== rtl/modexp_div.sv =====
// Restoring bit-serial remainder unit: unsigned 62-bit dividend by 31-bit
// divisor, one dividend bit per cycle. Uses modexp_pkg.
module modexp_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [modexp_pkg::ProdW-1:0] dividend,
    input  logic [modexp_pkg::OpW-1:0]  divisor,
    output logic                        done,
    output logic [modexp_pkg::OpW-1:0]  remainder
);
    logic [modexp_pkg::ProdW-1:0] dvd_reg, dvd_next;
    logic [modexp_pkg::OpW:0]     rem_reg, rem_next;
    logic [5:0]                   cnt_reg, cnt_next;
    logic                         busy_reg, busy_next;
    logic [modexp_pkg::OpW+1:0]   trial;

    always_comb begin
        dvd_next  = dvd_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        trial     = {rem_reg, dvd_reg[modexp_pkg::ProdW-1]} - {2'b00, divisor};
        done      = 1'b0;
        if (start) begin
            dvd_next  = dividend;
            rem_next  = '0;
            cnt_next  = 6'(modexp_pkg::ProdW - 1);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[modexp_pkg::ProdW-2:0], 1'b0};
            if (!trial[modexp_pkg::OpW+1])
                rem_next = trial[modexp_pkg::OpW:0];
            else
                rem_next = {rem_reg[modexp_pkg::OpW-1:0], dvd_reg[modexp_pkg::ProdW-1]};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done      = 1'b1;
            end else
                cnt_next = cnt_reg - 6'd1;
        end
    end

    assign remainder = rem_next[modexp_pkg::OpW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
        end
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        cnt_reg <= cnt_next;
    end
endmodule

// ===== rtl/modexp_seq.sv =====
// Sequencer for square and multiply: walks the exponent bits and starts the
// shared reduction unit. Uses modexp_pkg.
module modexp_seq (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       in_go,
    input  logic [modexp_pkg::OpW-1:0] exponent,
    input  logic                       div_done,
    input  logic                       out_taken,
    output logic                       idle,
    output logic                       result_valid,
    output logic                       exp_zero,
    output logic                       mul_step,
    output modexp_pkg::div_ctrl_t      ctrl
);
    modexp_pkg::state_t state_reg, state_next;
    modexp_pkg::state_t ret_reg, ret_next;
    logic [modexp_pkg::OpW-1:0] exp_reg, exp_next;
    logic [1:0] sel_reg, sel_next;
    logic zero_reg, zero_next;  // word arrived with a zero exponent

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= modexp_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        ret_reg  <= ret_next;
        exp_reg  <= exp_next;
        sel_reg  <= sel_next;
        zero_reg <= zero_next;
    end

    always_comb begin
        state_next   = state_reg;
        ret_next     = ret_reg;
        exp_next     = exp_reg;
        sel_next     = sel_reg;
        zero_next    = zero_reg;
        ctrl.start   = 1'b0;
        ctrl.sel     = sel_reg;
        idle         = 1'b0;
        result_valid = 1'b0;
        mul_step     = 1'b0;
        exp_zero     = zero_reg;
        case (state_reg)
            modexp_pkg::ST_IDLE: begin
                idle = 1'b1;
                if (in_go) begin
                    exp_next   = exponent;
                    zero_next  = (exponent == '0);
                    state_next = (exponent == '0) ? modexp_pkg::ST_DONE
                                                  : modexp_pkg::ST_RED_BASE;
                end
            end
            modexp_pkg::ST_RED_BASE: begin
                ctrl.start = 1'b1;
                ctrl.sel   = modexp_pkg::SEL_BASE;
                sel_next   = modexp_pkg::SEL_BASE;
                ret_next   = modexp_pkg::ST_MUL;
                state_next = modexp_pkg::ST_DIV_WAIT;
            end
            modexp_pkg::ST_MUL: begin
                if (exp_reg == '0) begin
                    state_next = modexp_pkg::ST_DONE;
                end else if (exp_reg[0]) begin
                    ctrl.start = 1'b1;
                    ctrl.sel   = modexp_pkg::SEL_MUL;
                    sel_next   = modexp_pkg::SEL_MUL;
                    ret_next   = modexp_pkg::ST_SQR;
                    state_next = modexp_pkg::ST_DIV_WAIT;
                end else
                    state_next = modexp_pkg::ST_SQR;
            end
            modexp_pkg::ST_SQR: begin
                ctrl.start = 1'b1;
                ctrl.sel   = modexp_pkg::SEL_SQR;
                sel_next   = modexp_pkg::SEL_SQR;
                exp_next   = exp_reg >> 1;
                ret_next   = modexp_pkg::ST_MUL;
                state_next = modexp_pkg::ST_DIV_WAIT;
            end
            modexp_pkg::ST_DIV_WAIT: begin
                if (div_done) state_next = ret_reg;
            end
            modexp_pkg::ST_DONE: begin
                result_valid = 1'b1;
                if (out_taken) state_next = modexp_pkg::ST_IDLE;
            end
            default: state_next = modexp_pkg::ST_IDLE;
        endcase
        mul_step = (state_reg == modexp_pkg::ST_DIV_WAIT) && div_done
                   && (sel_reg == modexp_pkg::SEL_MUL);
    end
endmodule

// ===== rtl/modular_exponentiation.sv =====
// Top level of the modular exponentiation block: operand registers, the
// shared multiplier and remainder unit. Uses modexp_pkg, modexp_seq, modexp_div.
//
//  channel | ports      | payload
//  input   | s_axis_*   | tdata[31:0] base_value, [62:32] exponent, [93:63] modulus
//  result  | m_axis_*   | tdata[31:0] residue
//
// The base is reduced first; then each exponent bit, lowest first, costs a
// multiply when set and a squaring, each reduced by the bit-serial remainder unit.
// A zero exponent skips reduction. Ready only while idle; the result holds
// in its register until taken. Reset is synchronous, active low.
module modular_exponentiation (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,  // base_value, exponent, modulus, 2 zero bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata   // residue
);
    logic in_go, div_done, idle, exp_zero, mul_step;
    modexp_pkg::div_ctrl_t ctrl;
    logic [modexp_pkg::OpW-1:0] mod_reg, sq_reg, acc_reg, rem;
    logic neg_reg;
    logic [modexp_pkg::BaseW-1:0] babs_reg;  // up to 2^31 for the most negative base
    logic [modexp_pkg::ProdW-1:0] prod_reg, prod_next;
    logic [modexp_pkg::OpW-1:0] a_op, b_op;

    assign in_go = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = idle;

    modexp_seq u_seq (
        .aclk(aclk), .aresetn(aresetn), .in_go(in_go),
        .exponent(s_axis_tdata[62:32]), .div_done(div_done),
        .out_taken(m_axis_tready), .idle(idle), .result_valid(m_axis_tvalid),
        .exp_zero(exp_zero), .mul_step(mul_step), .ctrl(ctrl)
    );

    // magnitudes only; the sign of every residue is the base sign, and only
    // odd powers keep it, handled when the result is formed
    always_comb begin
        case (ctrl.sel)
            modexp_pkg::SEL_MUL: begin a_op = acc_reg; b_op = sq_reg; end
            modexp_pkg::SEL_SQR: begin a_op = sq_reg;  b_op = sq_reg; end
            default:             begin a_op = '0;      b_op = '0;     end
        endcase
        prod_next = modexp_pkg::ProdW'(a_op) * modexp_pkg::ProdW'(b_op);
        if (ctrl.sel == modexp_pkg::SEL_BASE)
            prod_next = modexp_pkg::ProdW'(babs_reg);
    end

    // product registered together with the delayed start, so the remainder unit loads the registered product
    logic start_d;
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        if (!aresetn) start_d <= 1'b0;
        else          start_d <= ctrl.start;
    end

    modexp_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(start_d),
        .dividend(prod_reg), .divisor(mod_reg),
        .done(div_done), .remainder(rem)
    );

    logic odd_reg;  // parity of exponent: negative sign survives only when odd
    logic [modexp_pkg::BaseW-1:0] base_mag;
    assign base_mag = s_axis_tdata[31] ? -s_axis_tdata[31:0] : s_axis_tdata[31:0];

    always_ff @(posedge aclk) begin
        if (in_go) begin
            neg_reg  <= s_axis_tdata[31];
            babs_reg <= base_mag;
            mod_reg  <= s_axis_tdata[93:63];
            odd_reg  <= s_axis_tdata[32];
            acc_reg  <= 31'd1;
        end
        if (div_done) begin
            if (mul_step) acc_reg <= rem;
            else          sq_reg  <= rem;
        end
    end

    logic [31:0] res_mag;
    always_comb begin
        res_mag = {1'b0, acc_reg};
        // no reduction possible with a zero modulus, unless the exponent is zero
        if (mod_reg == '0 && !exp_zero) res_mag = '0;
    end

    // exponent-zero words skip reduction; acc stays at one
    assign m_axis_tdata = (neg_reg && odd_reg) ? -res_mag : res_mag;

`ifndef ASSERT_OFF
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
    a_div_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.start |-> !s_axis_tready) else $error("reduction started while idle");
    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("result changed while stalled");
`endif
endmodule

// ===== bench/modexp_checker.sv =====
// Checker for the modular exponentiation block: watches both stream channels,
// predicts each residue and compares. Depends on nothing but the port widths.
`timescale 1ns / 100ps

module modexp_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,
    output int          fail_count,
    output int          pending
);

    logic [31:0] residue_q[$];

    // truncated-remainder square and multiply, sign follows the base
    function automatic logic [31:0] power_mod(logic [31:0] b_raw, logic [30:0] e_raw,
                                              logic [30:0] m_raw);
        longint acc;
        longint sq;
        longint m;
        logic [30:0] e;
        acc = 1;
        e = e_raw;
        m = longint'(m_raw);
        if (e == 0) return 32'd1;
        if (m == 0) return 32'd0;
        sq = longint'($signed(b_raw)) % m;
        while (e != 0) begin
            if (e[0]) acc = (acc * sq) % m;
            e = e >> 1;
            sq = (sq * sq) % m;
        end
        return acc[31:0];
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch: %s got %0d expected %0d at %0t", what,
                 $signed(got), $signed(want), $realtime);
        fail_count++;
    endtask

    initial fail_count = 0;
    assign pending = residue_q.size();

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready)
                residue_q.push_back(power_mod(s_axis_tdata[31:0], s_axis_tdata[62:32],
                                              s_axis_tdata[93:63]));
            if (m_axis_tvalid && m_axis_tready) begin
                if (residue_q.size() == 0)
                    report("unexpected word", m_axis_tdata, 32'd0);
                else if (m_axis_tdata !== residue_q[0])
                    report("residue", m_axis_tdata, residue_q.pop_front());
                else
                    void'(residue_q.pop_front());
            end
        end
    end

endmodule

// ===== bench/modular_exponentiation_test.sv =====
// Top of the modular exponentiation testbench: clock, reset, stimulus and
// verdict. Depends on modular_exponentiation and modexp_checker.
`timescale 1ns / 100ps

module modular_exponentiation_test;

    localparam int RandomWords = 268;
    localparam int IdleLimit   = 200000;

    logic        aclk;
    logic        aresetn;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [95:0] s_axis_tdata;   // base_value, exponent, modulus, 2 zero bits
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // residue
    int          fail_count;
    int          pending;
    int          idle_cycles;
    bit          sink_quiet;     // no random stalls on the result side
    bit          holding_off;

    modular_exponentiation i_dut (.*);

    modexp_checker i_checker (.*);

    initial aclk = 1'b0;
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watchdog: cycles with no word moving on either side
    always @(posedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: random stalls, plus one long hold-off counted here
    initial begin
        m_axis_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (holding_off) begin
                m_axis_tready <= 1'b0;
                repeat (3000) @(negedge aclk);
                holding_off = 1'b0;
            end
            m_axis_tready <= sink_quiet ? 1'b1 : ($urandom_range(99) >= 34);
        end
    end

    task automatic send(logic [31:0] b, logic [30:0] e, logic [30:0] m, bit gaps);
        while (gaps && $urandom_range(99) < 34) begin
            s_axis_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, m, e, b};
        @(posedge aclk);
        while (!s_axis_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [30:0] short_exp();
        return 31'($urandom_range(255));
    endfunction

    initial begin
        logic [31:0] b;
        logic [30:0] e;
        logic [30:0] m;
        idle_cycles   = 0;
        sink_quiet    = 1'b0;
        holding_off   = 1'b0;
        aresetn       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (9) @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes, exponent zero, modulus one, negative bases
        send(32'd5, 31'd0, 31'd1, 1'b0);
        send(32'h8000_0000, 31'd0, 31'h7FFF_FFFF, 1'b0);
        send(32'd7, 31'd3, 31'd1, 1'b0);
        send(32'hFFFF_FFFF, 31'd1, 31'd1, 1'b0);
        send(32'd2, 31'd10, 31'd1000, 1'b0);
        send(-32'sd3, 31'd3, 31'd7, 1'b1);
        send(-32'sd3, 31'd4, 31'd7, 1'b1);
        send(32'h8000_0000, 31'd1, 31'h7FFF_FFFF, 1'b1);
        send(32'h8000_0000, 31'd2, 31'd3, 1'b1);
        send(32'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        send(32'h7FFF_FFFE, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        send(32'h8000_0001, 31'h7FFF_FFFF, 31'h7FFF_FFFE, 1'b1);
        send(32'd0, 31'd5, 31'd13, 1'b1);
        send(-32'sd1, 31'h7FFF_FFFF, 31'd2, 1'b1);
        send(32'd3, 31'h5555_5555, 31'h2AAA_AAAB, 1'b1);
        send(-32'sd12345, 31'h2AAA_AAAA, 31'h7FFF_FFED, 1'b1);

        // long hold-off on the result side while words are offered
        holding_off = 1'b1;
        repeat (6) send($urandom, short_exp(), 31'($urandom_range(1, 1000)), 1'b0);

        for (int i = 0; i < RandomWords; i++) begin
            sink_quiet = (i >= 120 && i < 160);
            b = $urandom;
            m = (i % 5 == 0) ? 31'($urandom_range(1, 3)) : 31'($urandom | 1) | 31'd1;
            m = (m == 0) ? 31'd1 : m;
            // most exponents short to keep run time down; a few full width
            e = (i % 16 == 0) ? 31'($urandom) : short_exp();
            send(b, e, m, !sink_quiet);
        end
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(negedge aclk);
        repeat (100) @(negedge aclk);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
